// ----- src/cubic_table_interpolator_defines.svh -----
// Assertion helpers for the cubic table interpolator.
`ifndef CUBIC_TABLE_INTERPOLATOR_DEFINES_SVH
`define CUBIC_TABLE_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, ignored while reset is high.
`define CTI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CTI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTI_ASSERT(lbl, clk, rst, prop, msg)
`define CTI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/cti_pkg.sv -----
package cti_pkg;
   localparam int TABLE_ENTRIES_DEF = 1024;
   localparam int Z_STEP_DEF = 10;
   localparam int FRAC_BITS = 22;
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 24;
   localparam int SCALE_W = 32;
   localparam int OUT_W = 26;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_QUERY = 1'b1
   } op_type;
endpackage

// ----- src/cubic_table_interpolator.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    operation, entry_index, entry_value, scale_factor
// rsp      out        rsp_valid/rsp_ready    interpolated_value (one per query)
//
// One item enters per cycle while req_ready is high. The restoring divider resolves
// one quotient bit per stage.
// Loads write the four-bank table in order with queries and leave no result.
// Reset clears the stage valid bits only; the table is not cleared.
// A stage holds while the stage below it is full and stalled, so stalls drop nothing.
`include "cubic_table_interpolator_defines.svh"

module cubic_table_interpolator #(
   parameter int TABLE_ENTRIES = cti_pkg::TABLE_ENTRIES_DEF,
   parameter int Z_STEP = cti_pkg::Z_STEP_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [cti_pkg::INDEX_W-1:0]          req_entry_index,
   input  logic [cti_pkg::VALUE_W-1:0]          req_entry_value,
   input  logic [cti_pkg::SCALE_W-1:0]          req_scale_factor,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cti_pkg::OUT_W-1:0]     rsp_interpolated_value
);
   import cti_pkg::*;

   localparam int IXW = $clog2(TABLE_ENTRIES);
   localparam int IW = $clog2(TABLE_ENTRIES - 2);
   localparam int QW = IW + FRAC_BITS;
   localparam int DW = SCALE_W + $clog2(Z_STEP);
   localparam int BANK_D = (TABLE_ENTRIES + 3) / 4;
   localparam int RW = (BANK_D > 1) ? $clog2(BANK_D) : 1;
   localparam int JW = IXW + 2;

   localparam int ST_E = QW + 1;
   localparam int ST_R = QW + 2;
   localparam int ST_M2 = QW + 3;
   localparam int ST_M3 = QW + 4;
   localparam int ST_M4 = QW + 5;
   localparam int ST_O = QW + 6;
   localparam int NS = QW + 7;

   localparam int TW = 25;
   localparam int OW = 26;
   localparam int CPW = TW + OW;
   localparam int CW = 27;
   localparam int PW = CW + 27;
   localparam int WW = 31;
   localparam int YW = VALUE_W + 1;
   localparam int PRW = WW + YW;
   localparam int SW = PRW + 1;
   localparam int AW = PRW + 2;
   localparam int SHW = AW - FRAC_BITS;

   localparam logic [SCALE_W-1:0] A_ONE = SCALE_W'(64'h8000_0000);
   localparam logic signed [TW-1:0] ONE_T = TW'(1 << FRAC_BITS);
   localparam logic signed [TW-1:0] T_LO = -TW'(2 << FRAC_BITS);
   localparam logic signed [OW-1:0] ONE_O = OW'(1 << FRAC_BITS);
   localparam logic signed [CW-1:0] ONE_C = CW'(1 << FRAC_BITS);
   localparam logic signed [CW-1:0] HALF_C = CW'(1 << (FRAC_BITS - 1));
   localparam logic signed [AW-1:0] ROUND_A = AW'(1 << (FRAC_BITS - 1));
   localparam logic signed [SHW-1:0] OUT_MAX = SHW'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [SHW-1:0] OUT_MIN = -SHW'(1 << (OUT_W - 1));

   typedef struct packed {
      logic                 query;
      logic [INDEX_W-1:0]   widx;
      logic [VALUE_W-1:0]   wval;
      logic                 aneg;
      logic                 azero;
      logic                 ovf;
      logic [SCALE_W-1:0]   num;
      logic [DW-1:0]        den;
      logic [DW-1:0]        rem;
      logic [QW-1:0]        quo;
   } div_type;

   typedef struct packed {
      logic                 query;
      logic [INDEX_W-1:0]   widx;
      logic [VALUE_W-1:0]   wval;
      logic                 sat;
      logic [IXW-1:0]       base;
      logic signed [TW-1:0] t;
   } prep_type;

   // ---------------- valid bits and stage advance ----------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   adv;

   assign adv[NS] = rsp_ready;
   for (genvar k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[ST_O];

   prep_type e_ff;

   always_comb begin
      vld_in = {vld_ff[NS-2:0], req_valid};
      // drop loads once they have written the table
      vld_in[ST_R] = vld_ff[ST_E] && e_ff.query;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   // ---------------- entry stage: numerator and denominator ----------------
   div_type div_ff [QW+1];
   div_type div_in [QW+1];

   always_comb begin
      div_in[0] = '0;
      div_in[0].query = (op_type'(req_operation) == OP_QUERY);
      div_in[0].widx = req_entry_index;
      div_in[0].wval = req_entry_value;
      div_in[0].aneg = req_scale_factor > A_ONE;
      div_in[0].azero = (req_scale_factor == '0);
      div_in[0].num = (req_scale_factor > A_ONE) ? req_scale_factor - A_ONE
                                                 : A_ONE - req_scale_factor;
      div_in[0].den = DW'(req_scale_factor) * DW'(Z_STEP);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) div_ff[0] <= div_in[0];
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   for (genvar s = 0; s < QW; s++) begin : g_div
      localparam int KB = QW - 1 - s;
      logic [DW-1:0] rem_start;
      logic          ovf_cur;
      logic          din;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (s == 0) begin : g_first
         assign rem_start = DW'(div_ff[0].num >> IW);
         assign ovf_cur = (DW + IW)'(div_ff[0].num) >= {div_ff[0].den, {IW{1'b0}}};
      end else begin : g_rest
         assign rem_start = div_ff[s].rem;
         assign ovf_cur = div_ff[s].ovf;
      end

      if (KB >= FRAC_BITS) begin : g_numbit
         assign din = div_ff[s].num[KB-FRAC_BITS];
      end else begin : g_zerobit
         assign din = 1'b0;
      end

      assign trial = {rem_start, din};
      assign diff = trial - {1'b0, div_ff[s].den};
      assign ge = trial >= {1'b0, div_ff[s].den};

      always_comb begin
         div_in[s+1] = div_ff[s];
         div_in[s+1].ovf = ovf_cur;
         div_in[s+1].rem = ge ? diff[DW-1:0] : trial[DW-1:0];
         div_in[s+1].quo[KB] = ge;
      end

      always_ff @(posedge clock) begin
         if (adv[s+1]) div_ff[s+1] <= div_in[s+1];
      end
   end

   // ---------------- index and fraction ----------------
   prep_type             e_in;
   logic [IW-1:0]        ip;
   logic signed [TW-1:0] frac_s;
   logic                 ip_zero;
   logic [IXW-1:0]       i1;

   always_comb begin
      ip = div_ff[QW].quo[QW-1:FRAC_BITS];
      frac_s = TW'(div_ff[QW].quo[FRAC_BITS-1:0]);
      ip_zero = (ip == '0);
      i1 = (div_ff[QW].aneg || ip_zero) ? IXW'(1) : IXW'(ip);
      e_in.query = div_ff[QW].query;
      e_in.widx = div_ff[QW].widx;
      e_in.wval = div_ff[QW].wval;
      e_in.sat = div_ff[QW].azero || div_ff[QW].ovf ||
                 (!div_ff[QW].aneg && ((IW + 1)'(ip) >= (IW + 1)'(TABLE_ENTRIES - 2)));
      // the last entry lands in the fourth tap
      e_in.base = e_in.sat ? IXW'(TABLE_ENTRIES - 4) : i1 - IXW'(1);
      if (div_ff[QW].aneg) begin
         e_in.t = -ONE_T - frac_s;
      end else if (ip_zero) begin
         e_in.t = frac_s - ONE_T;
      end else begin
         e_in.t = frac_s;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_E]) e_ff <= e_in;
   end

   // ---------------- table banks and first product ----------------
   logic [VALUE_W-1:0] rd_ff [4];
   logic [1:0]         off [4];
   logic [JW-1:0]      jsum [4];
   logic [11:0]        widx_ext;
   logic               wr_en;

   assign widx_ext = 12'(e_ff.widx);
   assign wr_en = vld_ff[ST_E] && !e_ff.query && (13'(e_ff.widx) < 13'(TABLE_ENTRIES));

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [VALUE_W-1:0] mem [BANK_D];
      assign off[b] = 2'(b) - e_ff.base[1:0];
      assign jsum[b] = JW'(e_ff.base) + JW'(off[b]);

      always_ff @(posedge clock) begin
         if (adv[ST_R]) begin
            if (wr_en && (e_ff.widx[1:0] == 2'(b))) mem[widx_ext[RW+1:2]] <= e_ff.wval;
            rd_ff[b] <= mem[jsum[b][RW+1:2]];
         end
      end
   end

   logic signed [TW-1:0]  t_r;
   logic signed [OW-1:0]  omt_r;
   logic signed [TW+1:0]  t3_r;
   logic signed [CW-1:0]  t15_r;
   logic signed [CPW-1:0] ctp_r;

   logic                  r_sat_ff;
   logic [1:0]            r_blo_ff;
   logic signed [TW-1:0]  r_t_ff;
   logic signed [OW-1:0]  r_omt_ff;
   logic signed [CW-1:0]  r_t15_ff;
   logic signed [CPW-1:0] r_ctp_ff;

   always_comb begin
      t_r = e_ff.t;
      omt_r = ONE_O - OW'(t_r);
      t3_r = ((TW + 2)'(t_r) <<< 1) + (TW + 2)'(t_r);
      t15_r = CW'(t3_r >>> 1);
      ctp_r = t_r * omt_r;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_R]) begin
         r_sat_ff <= e_ff.sat;
         r_blo_ff <= e_ff.base[1:0];
         r_t_ff <= t_r;
         r_omt_ff <= omt_r;
         r_t15_ff <= t15_r;
         r_ctp_ff <= ctp_r;
      end
   end

   // ---------------- weight products ----------------
   logic [VALUE_W-1:0]   y_m [4];
   logic signed [CW-1:0] ct_m;
   logic signed [CW-1:0] onem_m;
   logic signed [CW-1:0] t15h_m;

   always_comb begin
      logic [1:0] sel;
      for (int k = 0; k < 4; k++) begin
         sel = r_blo_ff + 2'(k);
         y_m[k] = rd_ff[sel];
      end
      ct_m = CW'(r_ctp_ff >>> FRAC_BITS);
      onem_m = ONE_C - r_t15_ff;
      t15h_m = r_t15_ff - HALF_C;
   end

   logic                 m2_sat_ff;
   logic [VALUE_W-1:0]   m2_y_ff [4];
   logic signed [TW-1:0] m2_t_ff;
   logic signed [OW-1:0] m2_omt_ff;
   logic signed [PW-1:0] m2_pa_ff;
   logic signed [PW-1:0] m2_pb_ff;
   logic signed [PW-1:0] m2_pc_ff;
   logic signed [PW-1:0] m2_pd_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_M2]) begin
         m2_sat_ff <= r_sat_ff;
         m2_y_ff <= y_m;
         m2_t_ff <= r_t_ff;
         m2_omt_ff <= r_omt_ff;
         m2_pa_ff <= ct_m * r_omt_ff;
         m2_pb_ff <= ct_m * r_t_ff;
         m2_pc_ff <= ct_m * onem_m;
         m2_pd_ff <= ct_m * t15h_m;
      end
   end

   // ---------------- weights times samples ----------------
   logic signed [WW-1:0] w_m [4];

   always_comb begin
      w_m[0] = WW'((-m2_pa_ff) >>> (FRAC_BITS + 1));
      w_m[3] = WW'((-m2_pb_ff) >>> (FRAC_BITS + 1));
      w_m[1] = WW'(m2_omt_ff) + WW'(m2_pc_ff >>> FRAC_BITS);
      w_m[2] = WW'(m2_t_ff) + WW'(m2_pd_ff >>> FRAC_BITS);
   end

   logic                  m3_sat_ff;
   logic [VALUE_W-1:0]    m3_ylast_ff;
   logic signed [PRW-1:0] m3_p_ff [4];

   always_ff @(posedge clock) begin
      if (adv[ST_M3]) begin
         m3_sat_ff <= m2_sat_ff;
         m3_ylast_ff <= m2_y_ff[3];
         for (int k = 0; k < 4; k++) begin
            m3_p_ff[k] <= w_m[k] * $signed({1'b0, m2_y_ff[k]});
         end
      end
   end

   // ---------------- pairwise sums ----------------
   logic                 m4_sat_ff;
   logic [VALUE_W-1:0]   m4_ylast_ff;
   logic signed [SW-1:0] m4_s01_ff;
   logic signed [SW-1:0] m4_s23_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_M4]) begin
         m4_sat_ff <= m3_sat_ff;
         m4_ylast_ff <= m3_ylast_ff;
         m4_s01_ff <= SW'(m3_p_ff[0]) + SW'(m3_p_ff[1]);
         m4_s23_ff <= SW'(m3_p_ff[2]) + SW'(m3_p_ff[3]);
      end
   end

   // ---------------- round, saturate, output register ----------------
   logic signed [AW-1:0]    acc_o;
   logic signed [SHW-1:0]   sh_o;
   logic signed [OUT_W-1:0] out_in;
   logic signed [OUT_W-1:0] out_ff;

   always_comb begin
      acc_o = AW'(m4_s01_ff) + AW'(m4_s23_ff) + ROUND_A;
      sh_o = SHW'(acc_o >>> FRAC_BITS);
      priority if (m4_sat_ff) begin
         out_in = OUT_W'({1'b0, m4_ylast_ff});
      end else if (sh_o > OUT_MAX) begin
         out_in = OUT_W'(OUT_MAX);
      end else if (sh_o < OUT_MIN) begin
         out_in = OUT_W'(OUT_MIN);
      end else begin
         out_in = OUT_W'(sh_o);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_O]) out_ff <= out_in;
   end

   assign rsp_interpolated_value = out_ff;

   // ---------------- checks ----------------
   `CTI_ASSERT(a_div_rem, clock, reset, vld_ff[QW] && div_ff[QW].query && !div_ff[QW].ovf && !div_ff[QW].azero |-> div_ff[QW].rem < div_ff[QW].den, "divider remainder not below denominator")
   `CTI_ASSERT(a_neg_int, clock, reset, vld_ff[QW] && div_ff[QW].query && div_ff[QW].aneg |-> div_ff[QW].quo[QW-1:FRAC_BITS] == '0, "integer part set for scale factor above one")
   `CTI_ASSERT(a_t_range, clock, reset, vld_ff[ST_E] && e_ff.query && !e_ff.sat |-> (e_ff.t > T_LO) && (e_ff.t < ONE_T), "fraction out of range")
   `CTI_ASSERT(a_entry, clock, reset, req_valid && req_ready |=> vld_ff[0], "accepted transfer not captured")
endmodule

// ----- dv/tb_cubic_table_interpolator.sv -----
module tb_cubic_table_interpolator;
   timeunit 1ns;
   timeprecision 1ps;
   import cti_pkg::*;

   localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
   localparam int STEP = Z_STEP_DEF;
   localparam int FILL_ENTRIES = 64;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint ONE_Q = longint'(1) << FRAC_BITS;
   localparam longint A_ONE = longint'(1) << 31;
   localparam longint OUT_MAX = (longint'(1) << 25) - 1;
   localparam longint OUT_MIN = -(longint'(1) << 25);
   // smallest a whose taps stay inside the filled low region
   localparam longint A_NEAR = A_ONE / (STEP * (FILL_ENTRIES - 2) + 1) + 1;
   // largest a that still lands past the table end
   localparam longint A_FAR = A_ONE / (STEP * (N_ENTRIES - 2) + 1);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = OP_LOAD;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic [VALUE_W-1:0] req_entry_value = '0;
   logic [SCALE_W-1:0] req_scale_factor = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_interpolated_value;

   logic [VALUE_W-1:0] samples [N_ENTRIES];
   logic signed [OUT_W-1:0] pending_values[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int checked = 0;
   int queries_sent = 0;
   int loads_sent = 0;
   int cycles = 0;

   cubic_table_interpolator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_scale_factor(req_scale_factor),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_interpolated_value(rsp_interpolated_value)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_values.size());
         $display("[cubic_table_interpolator] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Compare each result transfer against the oldest expected value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %0d", rsp_interpolated_value);
         end else begin
            logic signed [OUT_W-1:0] want;
            want = pending_values.pop_front();
            checked++;
            if (rsp_interpolated_value !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d, got %0d", want, rsp_interpolated_value);
            end
         end
      end
   end

   function automatic logic signed [OUT_W-1:0] interpolate_scale(logic [SCALE_W-1:0] sf);
      longint a, den, num, ip, rem, frac, t, base;
      longint y0, y1, y2, y3, omt, ct, t15, w0, w1, w2, w3, acc, v;
      a = longint'(sf);
      if (a == 0) return OUT_W'(samples[N_ENTRIES-1]);
      den = a * STEP;
      if (a <= A_ONE) begin
         num = A_ONE - a;
         ip = num / den;
         if (ip >= N_ENTRIES - 2) return OUT_W'(samples[N_ENTRIES-1]);
         rem = num - ip * den;
         frac = (rem << FRAC_BITS) / den;
         if (ip == 0) begin
            base = 1;
            t = frac - ONE_Q;
         end else begin
            base = ip;
            t = frac;
         end
      end else begin
         num = a - A_ONE;
         base = 1;
         t = -ONE_Q - ((num << FRAC_BITS) / den);
      end
      y0 = samples[base-1];
      y1 = samples[base];
      y2 = samples[base+1];
      y3 = samples[base+2];
      omt = ONE_Q - t;
      // arithmetic shifts of signed values round toward minus infinity
      ct = (t * omt) >>> FRAC_BITS;
      t15 = (3 * t) >>> 1;
      w0 = (-ct * omt) >>> (FRAC_BITS + 1);
      w3 = (-ct * t) >>> (FRAC_BITS + 1);
      w1 = omt + ((ct * (ONE_Q - t15)) >>> FRAC_BITS);
      w2 = t + ((ct * (t15 - (ONE_Q >>> 1))) >>> FRAC_BITS);
      acc = w0 * y0 + w1 * y1 + w2 * y2 + w3 * y3;
      v = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      return OUT_W'(v);
   endfunction

   task automatic send_item(op_type op, int idx, logic [VALUE_W-1:0] val,
                            logic [SCALE_W-1:0] sf);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_entry_index <= INDEX_W'(idx);
      req_entry_value <= val;
      req_scale_factor <= sf;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_LOAD) begin
         samples[idx] = val;
         loads_sent++;
      end else begin
         pending_values = {pending_values, interpolate_scale(sf)};
         queries_sent++;
      end
   endtask

   function automatic logic [SCALE_W-1:0] random_scale();
      int sel;
      sel = $urandom_range(0, 9);
      // a at or above one: index clamps to the first interval
      if (sel < 2) return $urandom() | 32'h8000_0000;
      // far redshift, zero included: last entry
      if (sel < 3) return SCALE_W'($urandom_range(0, SCALE_W'(A_FAR)));
      // spread from the top of the filled region down to z = 0 and a little past it
      return SCALE_W'(A_NEAR) + ($urandom() >> $urandom_range(1, 31));
   endfunction

   task automatic test_fill_table();
      for (int k = 0; k < FILL_ENTRIES; k++)
         send_item(OP_LOAD, k, VALUE_W'($urandom()), '0);
      for (int k = N_ENTRIES - 4; k < N_ENTRIES; k++)
         send_item(OP_LOAD, k, VALUE_W'($urandom()), '0);
   endtask

   task automatic test_directed();
      send_item(OP_LOAD, 0, '1, '0);
      send_item(OP_LOAD, 1, '0, '0);
      send_item(OP_LOAD, 2, '1, '0);
      send_item(OP_LOAD, 3, '0, '0);
      send_item(OP_LOAD, N_ENTRIES - 1, '1, '0);
      send_item(OP_QUERY, 0, '0, 32'h0);            // zero scale: last entry
      send_item(OP_QUERY, 0, '0, 32'h8000_0000);    // z = 0
      send_item(OP_QUERY, 0, '0, 32'h7FFF_FFFF);
      send_item(OP_QUERY, 0, '0, 32'h8000_0001);    // a above one
      send_item(OP_QUERY, 0, '0, 32'hFFFF_FFFF);
      send_item(OP_QUERY, 0, '0, 32'h1);            // far redshift
      send_item(OP_QUERY, 0, '0, 32'(A_ONE / (STEP * 2 + 1)));
      send_item(OP_QUERY, 0, '0, 32'(A_ONE / (STEP * (N_ENTRIES - 3) + 1)));
      send_item(OP_QUERY, 0, '0, 32'(A_ONE / (STEP * (N_ENTRIES - 2) + 1)));
      send_item(OP_QUERY, 0, '0, 32'(A_ONE / (STEP * (N_ENTRIES - 2) + 1)) + 1);
      send_item(OP_LOAD, 1, '1, '0);
      send_item(OP_LOAD, 0, '0, '0);
      send_item(OP_LOAD, 3, '1, '0);
      send_item(OP_QUERY, 0, '0, 32'hFFFF_FFFF);
      send_item(OP_QUERY, 0, '0, 32'hC000_0000);
   endtask

   task automatic test_random(int count, int idle, int stall);
      idle_pct = idle;
      stall_pct = stall;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 15)
            send_item(OP_LOAD, $urandom_range(0, FILL_ENTRIES - 1),
                      ($urandom_range(0, 3) == 0) ? {VALUE_W{$urandom_range(0, 1) == 1}}
                                                 : VALUE_W'($urandom()), '0);
         else
            send_item(OP_QUERY, $urandom(), VALUE_W'($urandom()), random_scale());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_table();
      test_directed();
      test_random(140, 0, 0);
      test_random(140, 84, 0);
      test_random(140, 0, 84);
      test_random(140, 7, 7);
      req_valid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d loads and %0d queries, %0d results checked, %0d mismatches",
               loads_sent, queries_sent, checked, mismatches);
      if (mismatches == 0)
         $display("[cubic_table_interpolator] OK");
      else
         $display("[cubic_table_interpolator] ERROR");
      $finish;
   end
endmodule
